// ===== hw/rtl/ofjrs_pkg.sv =====
// Package for the order filter, join and revenue sum block.
// Holds shared constants, register indexes and request codes; no dependencies.
package ofjrs_pkg;

	localparam int unsigned CUSTOMER_KEYS_DEF = 262144;
	localparam int unsigned ROW_BITS = 64;
	localparam int unsigned BIT_AW = $clog2(ROW_BITS);

	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	localparam logic [1:0] REG_CUTOFF = 2'd0;
	localparam logic [1:0] REG_SEGMENT = 2'd1;
	localparam logic [1:0] REG_CHECK = 2'd2;

	localparam logic [1:0] REQ_CUSTOMER = 2'd0;
	localparam logic [1:0] REQ_ORDER = 2'd1;
	localparam logic [1:0] REQ_LINEITEM = 2'd2;

	localparam logic [16:0] SEGMENT_NONE = 17'h1FFFF;

endpackage

// ===== hw/rtl/ofjrs_bitmap.sv =====
// Customer membership bitmap: a row-wide synchronous memory with a clearing sweep after reset
// and write-to-read forwarding. Depends on ofjrs_pkg.
module ofjrs_bitmap #(
	parameter int unsigned CUSTOMER_KEYS = ofjrs_pkg::CUSTOMER_KEYS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [$clog2(CUSTOMER_KEYS)-ofjrs_pkg::BIT_AW-1:0] rd_row,
	output logic [ofjrs_pkg::ROW_BITS-1:0] rd_data,
	input  logic wr_en,
	input  logic [ofjrs_pkg::ROW_BITS-1:0] wr_data,
	output logic busy
);
	import ofjrs_pkg::*;

	localparam int unsigned KEY_AW = $clog2(CUSTOMER_KEYS);
	localparam int unsigned ROW_AW = KEY_AW - BIT_AW;
	localparam int unsigned ROWS = (CUSTOMER_KEYS + ROW_BITS - 1) / ROW_BITS;
	localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] rd_q;
	logic [ROW_AW-1:0] rd_row_q;
	logic clr_busy_q;
	logic [ROW_AW-1:0] clr_row_q;
	logic fw_valid_q;
	logic [ROW_AW-1:0] fw_row_q;
	logic [ROW_BITS-1:0] fw_data_q;
	logic mem_we;
	logic [ROW_AW-1:0] mem_wa;
	logic [ROW_BITS-1:0] mem_wd;

	always_comb begin
		mem_we = clr_busy_q || wr_en;
		mem_wa = clr_busy_q ? clr_row_q : rd_row_q;
		mem_wd = clr_busy_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q <= '0;
			fw_valid_q <= 1'b0;
			fw_row_q <= '0;
			fw_data_q <= '0;
			rd_row_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == LAST_ROW) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (mem_we) begin
				fw_valid_q <= 1'b1;
				fw_row_q <= mem_wa;
				fw_data_q <= mem_wd;
			end
			if (rd_en) begin
				rd_row_q <= rd_row;
			end
		end
	end

	// A write at the same edge as the read is not seen by the memory read; take the newest row.
	assign rd_data = (fw_valid_q && fw_row_q == rd_row_q) ? fw_data_q : rd_q;
	assign busy = clr_busy_q;

endmodule

// ===== hw/rtl/order_filter_join_revenue_sum_top.sv =====
// Top level of the order filter, join and revenue sum block.
// Depends on ofjrs_pkg and ofjrs_bitmap.

// The block takes one transaction per clock cycle while in_ready is high. A customer transaction
// sets a bit in a membership bitmap held in a row-wide memory, an order transaction reads that
// bitmap to open a group, and lineitem transactions add qualifying prices to a 64-bit wrapping
// sum. The bitmap row is read at the edge that accepts a transaction, and the update stage acts
// on it when that transaction advances. A result is loaded into the output register when the
// update stage advances its closing lineitem. Apart from the clearing sweep, the input stalls
// only while a result waits in the output register and the lineitem in the update stage would
// emit another. After reset the bitmap is cleared one 64-bit row per cycle, CUSTOMER_KEYS/64 rows
// (4096 at the default size); configuration writes are taken during that sweep while in_ready
// stays low.
module order_filter_join_revenue_sum_top #(
	parameter int unsigned CUSTOMER_KEYS = ofjrs_pkg::CUSTOMER_KEYS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ofjrs_pkg::APB_AW-1:0] paddr,
	input  logic [ofjrs_pkg::APB_DW-1:0] pwdata,
	output logic [ofjrs_pkg::APB_DW-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] req_type,
	input  logic signed [31:0] cust_key,
	input  logic [15:0] segment,
	input  logic signed [31:0] order_key,
	input  logic signed [15:0] order_date,
	input  logic signed [31:0] ship_priority,
	input  logic no_items,
	input  logic signed [15:0] ship_date,
	input  logic signed [31:0] price,
	input  logic last_item,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] out_order_key,
	output logic signed [63:0] revenue,
	output logic signed [15:0] out_order_date,
	output logic signed [31:0] out_priority
);
	import ofjrs_pkg::*;

	localparam int unsigned KEY_AW = $clog2(CUSTOMER_KEYS);
	localparam int unsigned ROW_AW = KEY_AW - BIT_AW;

	logic signed [15:0] cutoff_q;
	logic [16:0] segment_code_q;
	logic check_q;
	logic cfg_we;

	logic in_fire;
	logic key_in_range;
	logic seg_match;
	logic [ROW_AW-1:0] rd_row;
	logic bm_busy;
	logic [ROW_BITS-1:0] row_data;
	logic bm_we;
	logic [ROW_BITS-1:0] bm_wd;

	logic s1_valid_s1;
	logic [1:0] type_s1;
	logic qual_s1;
	logic [BIT_AW-1:0] bit_s1;
	logic [31:0] order_key_s1;
	logic [15:0] order_date_s1;
	logic [31:0] priority_s1;
	logic ship_ok_s1;
	logic signed [31:0] price_s1;
	logic last_s1;

	logic group_open_q;
	logic [31:0] held_key_q;
	logic [15:0] held_date_q;
	logic [31:0] held_prio_q;
	logic [63:0] revenue_sum_q;
	logic any_counted_q;

	logic out_valid_q;
	logic [31:0] out_key_q;
	logic [63:0] out_rev_q;
	logic [15:0] out_date_q;
	logic [31:0] out_prio_q;

	logic bit_hit;
	logic count;
	logic [63:0] rev_new;
	logic emit;
	logic s1_adv;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= '0;
			segment_code_q <= SEGMENT_NONE;
			check_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_CUTOFF: cutoff_q <= pwdata[15:0];
				REG_SEGMENT: segment_code_q <= pwdata[16:0];
				REG_CHECK: check_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CUTOFF: prdata = {16'd0, cutoff_q};
			REG_SEGMENT: prdata = {15'd0, segment_code_q};
			REG_CHECK: prdata = {31'd0, check_q};
			default: prdata = '0;
		endcase
	end

	assign in_fire = in_valid && in_ready;
	assign key_in_range = !cust_key[31] && ($unsigned(cust_key) < 32'(CUSTOMER_KEYS));
	assign seg_match = !segment_code_q[16] && (segment_code_q[15:0] == segment);
	assign rd_row = cust_key[KEY_AW-1:BIT_AW];

	ofjrs_bitmap #(
		.CUSTOMER_KEYS(CUSTOMER_KEYS)
	) u_bitmap (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(in_fire),
		.rd_row(rd_row),
		.rd_data(row_data),
		.wr_en(bm_we),
		.wr_data(bm_wd),
		.busy(bm_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			type_s1 <= req_type;
			qual_s1 <= (req_type == REQ_CUSTOMER) ? (seg_match && key_in_range)
				: ((order_date < cutoff_q) && key_in_range && !no_items);
			bit_s1 <= cust_key[BIT_AW-1:0];
			order_key_s1 <= order_key;
			order_date_s1 <= order_date;
			priority_s1 <= ship_priority;
			ship_ok_s1 <= ship_date > cutoff_q;
			price_s1 <= price;
			last_s1 <= last_item;
		end
	end

	always_comb begin
		bit_hit = row_data[bit_s1];
		count = group_open_q && ship_ok_s1 && (!check_q || order_key_s1 == held_key_q);
		rev_new = revenue_sum_q + (count ? 64'(price_s1) : 64'd0);
		emit = (type_s1 == REQ_LINEITEM) && group_open_q && last_s1 && (any_counted_q || count);
		s1_adv = s1_valid_s1 && (!emit || !out_valid_q || out_ready);
		bm_we = s1_adv && (type_s1 == REQ_CUSTOMER) && qual_s1;
		bm_wd = row_data | (ROW_BITS'(1) << bit_s1);
		in_ready = !bm_busy && (!s1_valid_s1 || s1_adv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_open_q <= 1'b0;
			held_key_q <= '0;
			held_date_q <= '0;
			held_prio_q <= '0;
			revenue_sum_q <= '0;
			any_counted_q <= 1'b0;
		end else if (s1_adv) begin
			if (type_s1 == REQ_ORDER) begin
				group_open_q <= qual_s1 && bit_hit;
				held_key_q <= order_key_s1;
				held_date_q <= order_date_s1;
				held_prio_q <= priority_s1;
				revenue_sum_q <= '0;
				any_counted_q <= 1'b0;
			end else if (type_s1 == REQ_LINEITEM && group_open_q) begin
				revenue_sum_q <= rev_new;
				any_counted_q <= !last_s1 && (any_counted_q || count);
				if (last_s1) begin
					group_open_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			out_key_q <= held_key_q;
			out_rev_q <= rev_new;
			out_date_q <= held_date_q;
			out_prio_q <= held_prio_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_order_key = out_key_q;
	assign revenue = out_rev_q;
	assign out_order_date = out_date_q;
	assign out_priority = out_prio_q;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		bm_busy |-> !in_ready)
		else $error("input accepted during bitmap clearing sweep");

	a_emit_needs_open_group: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && emit) |-> group_open_q)
		else $error("group emitted while no group open");

	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_adv) |=> (s1_valid_s1 && $stable(type_s1) && $stable(price_s1)))
		else $error("update stage lost a stalled transaction");

	a_out_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && emit) |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending output");

endmodule

// ===== tb/sv/order_filter_join_revenue_sum_top_tb.sv =====
// Testbench for order_filter_join_revenue_sum_top: directed table, then random phases.
// Predicts each group result in SystemVerilog, or takes it from the directed table, and checks the output stream.
// Depends on ofjrs_pkg and the block's RTL only.
module order_filter_join_revenue_sum_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ofjrs_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ROWS = 245;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef enum logic [1:0] {PREDICTED, NO_GROUP, KNOWN_GROUP} outcome_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] cust_key;
		logic [15:0] segment;
		logic [31:0] order_key;
		logic [15:0] order_date;
		logic [31:0] ship_priority;
		logic no_items;
		logic [15:0] ship_date;
		logic [31:0] price;
		logic last_item;
	} row_t;

	typedef struct packed {
		logic [31:0] okey;
		logic [63:0] rev;
		logic [15:0] odate;
		logic [31:0] prio;
	} group_t;

	typedef struct packed {
		logic is_cfg;
		logic [1:0] reg_idx;
		logic [31:0] reg_val;
		row_t row;
		outcome_t how;
		group_t known;
	} plan_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_ready;
	logic [1:0] req_type;
	logic signed [31:0] cust_key;
	logic [15:0] segment;
	logic signed [31:0] order_key;
	logic signed [15:0] order_date;
	logic signed [31:0] ship_priority;
	logic no_items;
	logic signed [15:0] ship_date;
	logic signed [31:0] price;
	logic last_item;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] out_order_key;
	logic signed [63:0] revenue;
	logic signed [15:0] out_order_date;
	logic signed [31:0] out_priority;

	order_filter_join_revenue_sum_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.cust_key(cust_key),
		.segment(segment),
		.order_key(order_key),
		.order_date(order_date),
		.ship_priority(ship_priority),
		.no_items(no_items),
		.ship_date(ship_date),
		.price(price),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_order_key(out_order_key),
		.revenue(revenue),
		.out_order_date(out_order_date),
		.out_priority(out_priority)
	);

	bit member_bits [CUSTOMER_KEYS_DEF];
	bit grp_open = 1'b0;
	logic [31:0] grp_key = '0;
	logic [15:0] grp_date = '0;
	logic [31:0] grp_prio = '0;
	logic [63:0] grp_sum = '0;
	bit grp_counted = 1'b0;
	logic signed [15:0] cut_day = '0;
	logic [16:0] seg_want = SEGMENT_NONE;
	bit key_check = 1'b0;

	group_t groups_due [$];
	int bad_count = 0;
	int rows_sent = 0;
	int quiet_cycles = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always #(HALF_PERIOD) clk = ~clk;

	function automatic void join_and_sum(input row_t r, output bit emit, output group_t g);
		int ck;
		bit key_in;
		emit = 1'b0;
		g = '0;
		ck = $signed(r.cust_key);
		key_in = (ck >= 0) && (ck < int'(CUSTOMER_KEYS_DEF));
		case (r.kind)
		REQ_CUSTOMER: begin
			if (!seg_want[16] && r.segment == seg_want[15:0] && key_in)
				member_bits[ck] = 1'b1;
		end
		REQ_ORDER: begin
			grp_open = ($signed(r.order_date) < cut_day) && key_in && member_bits[ck]
				&& !r.no_items;
			grp_key = r.order_key;
			grp_date = r.order_date;
			grp_prio = r.ship_priority;
			grp_sum = '0;
			grp_counted = 1'b0;
		end
		REQ_LINEITEM: begin
			if (grp_open) begin
				if ((!key_check || r.order_key == grp_key) && $signed(r.ship_date) > cut_day) begin
					grp_sum += {{32{r.price[31]}}, r.price};
					grp_counted = 1'b1;
				end
				if (r.last_item) begin
					grp_open = 1'b0;
					if (grp_counted) begin
						emit = 1'b1;
						g = '{okey: grp_key, rev: grp_sum, odate: grp_date, prio: grp_prio};
						grp_counted = 1'b0;
					end
				end
			end
		end
		default: ;
		endcase
	endfunction

	function automatic group_t grp(logic [31:0] k, logic [63:0] rv, logic [15:0] d,
			logic [31:0] p);
		return '{okey: k, rev: rv, odate: d, prio: p};
	endfunction

	function automatic plan_t p_cfg(logic [1:0] idx, logic [31:0] v);
		plan_t p;
		p = '0;
		p.is_cfg = 1'b1;
		p.reg_idx = idx;
		p.reg_val = v;
		return p;
	endfunction

	function automatic plan_t p_cust(int ck, int seg);
		plan_t p;
		p = '0;
		p.row.kind = REQ_CUSTOMER;
		p.row.cust_key = ck;
		p.row.segment = 16'(seg);
		p.how = PREDICTED;
		return p;
	endfunction

	function automatic plan_t p_order(int ck, int okey, int d, int prio, bit none);
		plan_t p;
		p = '0;
		p.row.kind = REQ_ORDER;
		p.row.cust_key = ck;
		p.row.order_key = okey;
		p.row.order_date = 16'(d);
		p.row.ship_priority = prio;
		p.row.no_items = none;
		p.how = PREDICTED;
		return p;
	endfunction

	function automatic plan_t p_line(int okey, int ship, int pr, bit last, outcome_t how,
			group_t known);
		plan_t p;
		p = '0;
		p.row.kind = REQ_LINEITEM;
		p.row.order_key = okey;
		p.row.ship_date = 16'(ship);
		p.row.price = pr;
		p.row.last_item = last;
		p.how = how;
		p.known = known;
		return p;
	endfunction

	function automatic plan_t p_unused();
		plan_t p;
		p = '0;
		p.row = '1;
		p.row.kind = REQ_UNUSED;
		p.how = NO_GROUP;
		return p;
	endfunction

	function automatic row_t noise_row();
		row_t r;
		r.kind = 2'($urandom);
		r.cust_key = $urandom;
		r.segment = 16'($urandom);
		r.order_key = $urandom;
		r.order_date = 16'($urandom);
		r.ship_priority = $urandom;
		r.no_items = 1'($urandom);
		r.ship_date = 16'($urandom);
		r.price = $urandom;
		r.last_item = 1'($urandom);
		return r;
	endfunction

	function automatic logic [31:0] pick_cust();
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 45)
			return $urandom_range(255, 0);
		else if (pick < 80)
			return CUSTOMER_KEYS_DEF - 1 - $urandom_range(255, 0);
		else if (pick < 88)
			return CUSTOMER_KEYS_DEF + $urandom_range(4095, 0);
		return $urandom;
	endfunction

	function automatic int date_before();
		int c;
		int lo;
		logic signed [15:0] d;
		c = cut_day;
		if (c == -32768 || $urandom_range(99, 0) < 15) begin
			d = 16'($urandom);
			return d;
		end
		lo = (c - 300 < -32768) ? -32768 : c - 300;
		return lo + int'($urandom_range(c - 1 - lo, 0));
	endfunction

	function automatic int date_after();
		int c;
		int hi;
		logic signed [15:0] d;
		c = cut_day;
		if (c == 32767 || $urandom_range(99, 0) < 20) begin
			d = 16'($urandom);
			return d;
		end
		hi = (c + 300 > 32767) ? 32767 : c + 300;
		return c + 1 + int'($urandom_range(hi - c - 1, 0));
	endfunction

	function automatic logic [31:0] pick_price();
		if ($urandom_range(99, 0) < 30)
			return $urandom;
		return 32'($urandom_range(20000, 0)) - 32'd5000;
	endfunction

	task automatic log_bad(input string what, input group_t want, input group_t seen);
		bad_count++;
		if (bad_count <= 10) begin
			$display("%s: expected key %0d revenue %0d date %0d priority %0d,", what,
				$signed(want.okey), $signed(want.rev), $signed(want.odate),
				$signed(want.prio));
			$display("\tgot key %0d revenue %0d date %0d priority %0d",
				$signed(seen.okey), $signed(seen.rev), $signed(seen.odate),
				$signed(seen.prio));
		end
	endtask

	task automatic queue_group(input group_t g);
		groups_due = {groups_due, g};
	endtask

	task automatic send_row(input row_t r, input outcome_t how, input group_t known);
		bit emit;
		group_t g;
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		cust_key <= r.cust_key;
		segment <= r.segment;
		order_key <= r.order_key;
		order_date <= r.order_date;
		ship_priority <= r.ship_priority;
		no_items <= r.no_items;
		ship_date <= r.ship_date;
		price <= r.price;
		last_item <= r.last_item;
		do @(posedge clk); while (!in_ready);
		join_and_sum(r, emit, g);
		if (how == KNOWN_GROUP)
			queue_group(known);
		else if (how == PREDICTED && emit)
			queue_group(g);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (groups_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_CUTOFF: cut_day = val[15:0];
		REG_SEGMENT: seg_want = val[16:0];
		REG_CHECK: key_check = val[0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic random_group();
		row_t r;
		logic [31:0] okey;
		int n;
		bit broken;
		r = noise_row();
		r.kind = REQ_ORDER;
		r.cust_key = pick_cust();
		okey = r.order_key;
		r.order_date = 16'(($urandom_range(99, 0) < 85) ? date_before() : date_after());
		r.no_items = ($urandom_range(99, 0) < 8);
		send_row(r, PREDICTED, '0);
		rows_sent++;
		n = $urandom_range(5, 0);
		broken = ($urandom_range(99, 0) < 10);
		for (int i = 0; i < n; i++) begin
			r = noise_row();
			r.kind = REQ_LINEITEM;
			if ($urandom_range(99, 0) < 85)
				r.order_key = okey;
			r.ship_date = 16'(($urandom_range(99, 0) < 75) ? date_after() : date_before());
			r.price = pick_price();
			r.last_item = (i == n - 1) && !broken;
			send_row(r, PREDICTED, '0);
			rows_sent++;
		end
	endtask

	task automatic random_burst();
		int pick;
		int n;
		row_t r;
		pick = $urandom_range(99, 0);
		if (pick < 15) begin
			n = $urandom_range(12, 1);
			repeat (n) begin
				r = noise_row();
				r.kind = REQ_CUSTOMER;
				r.cust_key = pick_cust();
				if (!seg_want[16] && $urandom_range(99, 0) < 70)
					r.segment = seg_want[15:0];
				send_row(r, PREDICTED, '0);
				rows_sent++;
			end
		end else if (pick < 85) begin
			random_group();
		end else if (pick < 93) begin
			r = noise_row();
			r.kind = REQ_LINEITEM;
			send_row(r, PREDICTED, '0);
			rows_sent++;
		end else begin
			r = noise_row();
			send_row(r, PREDICTED, '0);
			if (r.kind != REQ_UNUSED)
				rows_sent++;
		end
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		group_t seen;
		group_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = '{okey: out_order_key, rev: revenue, odate: out_order_date,
				prio: out_priority};
			if (groups_due.size() == 0) begin
				log_bad("unexpected group", '0, seen);
			end else begin
				want = groups_due.pop_front();
				if (seen.okey != want.okey || seen.rev != want.rev || seen.odate != want.odate
						|| seen.prio != want.prio)
					log_bad("group mismatch", want, seen);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("order_filter_join_revenue_sum_top_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		plan_t plan [$];
		logic signed [15:0] cut;
		logic [16:0] seg;
		bit chk;
		int target;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = REQ_CUSTOMER;
		cust_key = '0;
		segment = '0;
		order_key = '0;
		order_date = '0;
		ship_priority = '0;
		no_items = 1'b0;
		ship_date = '0;
		price = '0;
		last_item = 1'b0;
		out_ready = 1'b0;

		plan = '{
			p_cust(7, 16'hFFFF),
			p_order(7, 10, -32768, 0, 1'b0),
			p_line(10, 32767, 5, 1'b1, NO_GROUP, '0),
			p_cfg(REG_CUTOFF, 32'd100),
			p_cfg(REG_SEGMENT, 32'd5),
			p_cfg(REG_CHECK, 32'd0),
			p_cust(0, 5),
			p_cust(262143, 5),
			p_cust(262144, 5),
			p_cust(-1, 5),
			p_cust(3, 6),
			p_order(0, 32'h7FFFFFFF, -32768, 32'h80000000, 1'b0),
			p_line(32'h7FFFFFFF, 101, 32'h7FFFFFFF, 1'b0, PREDICTED, '0),
			p_line(32'h7FFFFFFF, 100, 1, 1'b0, PREDICTED, '0),
			p_line(32'h7FFFFFFF, 32767, 32'h7FFFFFFF, 1'b1, KNOWN_GROUP,
				grp(32'h7FFFFFFF, 64'hFFFFFFFE, 16'h8000, 32'h80000000)),
			p_order(262143, -1, 99, 32'h7FFFFFFF, 1'b0),
			p_order(262144, 5, 0, 0, 1'b0),
			p_line(5, 200, 9, 1'b1, NO_GROUP, '0),
			p_order(0, 3, 50, 1, 1'b1),
			p_line(3, 200, 9, 1'b1, NO_GROUP, '0),
			p_order(0, 4, 100, 1, 1'b0),
			p_line(4, 200, 9, 1'b1, NO_GROUP, '0),
			p_order(262143, 6, 0, 2, 1'b0),
			p_line(6, 0, 3, 1'b1, NO_GROUP, '0),
			p_unused(),
			p_order(0, 8, -1, -1, 1'b0),
			p_line(8, 101, 32'h80000000, 1'b1, KNOWN_GROUP,
				grp(32'd8, 64'hFFFFFFFF80000000, 16'hFFFF, 32'hFFFFFFFF)),
			p_cfg(REG_CHECK, 32'd1),
			p_order(262143, 9, 99, 7, 1'b0),
			p_line(10, 200, 1, 1'b0, PREDICTED, '0),
			p_line(9, 200, 2, 1'b1, KNOWN_GROUP, grp(32'd9, 64'd2, 16'd99, 32'd7))
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_row(plan[i].row, plan[i].how, plan[i].known);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			cut = 16'($urandom_range(4000, 0) - 2000);
			seg = 17'($urandom_range(65535, 0));
			chk = 1'($urandom);
			case (ph)
			1: begin
				cut = 16'sh7FFF;
				seg = 17'd65535;
				chk = 1'b1;
			end
			2: begin
				cut = 16'sh8000;
				seg = 17'd0;
				chk = 1'b0;
			end
			3: begin
				seg = SEGMENT_NONE;
				chk = 1'b1;
			end
			5: begin
				cut = '0;
				seg = 17'd0;
				chk = 1'b1;
			end
			6: begin
				seg = 17'd65535;
				chk = 1'b0;
			end
			7: cut = 16'($urandom);
			default: ;
			endcase
			write_reg(REG_CUTOFF, {16'b0, cut});
			write_reg(REG_SEGMENT, {15'b0, seg});
			write_reg(REG_CHECK, {31'b0, chk});
			case (ph % 4)
			0: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			1: begin
				tx_idle_pct = 57;
				rx_stall_pct = 0;
			end
			2: begin
				tx_idle_pct = 0;
				rx_stall_pct = 57;
			end
			default: begin
				tx_idle_pct = 13;
				rx_stall_pct = 13;
			end
			endcase
			if (ph == 4)
				hold_asks++;
			target = rows_sent + PHASE_ROWS;
			while (rows_sent < target)
				random_burst();
		end

		settle();
		if (bad_count == 0)
			$display("order_filter_join_revenue_sum_top_tb: PASS");
		else
			$display("order_filter_join_revenue_sum_top_tb: FAIL");
		$finish;
	end

endmodule
